// ===== design/balist_pkg.sv =====
// Shared types and constants for the bounded array list engine.
// No dependencies; imported by balist_cell and bounded_array_list_engine_unit.
`default_nettype none

package balist_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_SEARCH = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_code_type;

   typedef struct packed {
      op_code_type             req_type;
      logic [3:0]              position;
      logic signed [31:0]      item_value;
      logic signed [31:0]      search_key;
   } req_payload_type;

   typedef struct packed {
      status_code_type         status;
      logic                    found;
      logic [3:0]              found_position;
      logic [4:0]              entry_count;
   } rsp_payload_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      op_code_type             op;
      logic [IDX_W-1:0]        pos;
      logic [CNT_W-1:0]        count;
      logic                    update;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== design/balist_cell.sv =====
// One list entry: holds a word, shifts from its neighbors on insert/delete,
// compares against the search key. Depends on balist_pkg.
`default_nettype none

module balist_cell
   import balist_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [IDX_W-1:0]      cell_index,
   input  wire cell_ctl_type          ctl,
   input  wire logic [DATA_WIDTH-1:0] item,
   input  wire logic [DATA_WIDTH-1:0] key,
   input  wire logic [DATA_WIDTH-1:0] left_entry,
   input  wire logic [DATA_WIDTH-1:0] right_entry,
   output logic      [DATA_WIDTH-1:0] entry,
   output logic                       match
);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic [CNT_W-1:0]      idx;
   logic [CNT_W-1:0]      idx_next;
   logic [CNT_W-1:0]      pos_ext;

   assign idx      = CNT_W'(cell_index);
   assign idx_next = idx + CNT_W'(1);
   assign pos_ext  = CNT_W'(ctl.pos);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.update) begin
         case (ctl.op)
            OP_APPEND: begin
               if (idx == ctl.count) entry_in = item;
            end
            OP_INSERT: begin
               if (idx == pos_ext) entry_in = item;
               else if (idx > pos_ext && idx <= ctl.count) entry_in = left_entry;
            end
            OP_DELETE: begin
               if (idx >= pos_ext && idx_next < ctl.count) entry_in = right_entry;
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (idx < ctl.count) && (entry_ff == key);

endmodule

`default_nettype wire

// ===== design/bounded_array_list_engine_unit.sv =====
// Bounded array list engine: one transaction is accepted, the cell chain updates
// in that cycle, the response is built from the registered match flags in the
// match stage and then registered in the response register.
// A new transaction is taken only once the match stage has passed the last one on;
// the match stage holds while a response waits on rsp_ready.
// Reset: entry count 0, capacity 16; entry contents undefined until written.
// Depends on balist_pkg and balist_cell.
`default_nettype none

module bounded_array_list_engine_unit
   import balist_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [4:0]      csr_data
);

   logic [4:0]              capacity_ff, capacity_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    mid_valid_ff, mid_valid_in;
   logic                    mid_search_ff, mid_search_in;
   status_code_type         mid_status_ff, mid_status_in;
   logic [CNT_W-1:0]        mid_count_ff, mid_count_in;
   logic [DEPTH-1:0]        match_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_ff, rsp_in;

   logic [CNT_W-1:0]        limit;
   logic                    full;
   logic [CNT_W-1:0]        pos_ext;
   logic                    req_fire;
   logic                    mid_move;
   status_code_type         status_now;
   logic                    do_update;
   cell_ctl_type            ctl;
   logic [DATA_WIDTH-1:0]   entry_bus [DEPTH];
   logic [DEPTH-1:0]        match_bus;
   logic                    hit;
   logic [IDX_W-1:0]        hit_pos;

   assign csr_ready = 1'b1;
   assign req_ready = !mid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign mid_move  = mid_valid_ff && (!rsp_valid_ff || rsp_ready);

   assign limit   = (capacity_ff > 5'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_ff);
   assign full    = count_ff >= limit;
   assign pos_ext = CNT_W'(req_payload.position);

   always_comb begin
      status_now = ST_OK;
      do_update  = 1'b0;
      count_in   = count_ff;
      unique case (req_payload.req_type)
         OP_APPEND: begin
            if (full) status_now = ST_FULL;
            else do_update = 1'b1;
         end
         OP_INSERT: begin
            if (full) status_now = ST_FULL;
            else if (pos_ext > count_ff) status_now = ST_RANGE;
            else do_update = 1'b1;
         end
         OP_DELETE: begin
            if (pos_ext >= count_ff) status_now = ST_RANGE;
            else do_update = 1'b1;
         end
         OP_SEARCH: status_now = ST_OK;
         default:   status_now = ST_OK;
      endcase
      if (req_fire && do_update) begin
         if (req_payload.req_type == OP_DELETE) count_in = count_ff - CNT_W'(1);
         else count_in = count_ff + CNT_W'(1);
      end
   end

   assign ctl.op     = req_payload.req_type;
   assign ctl.pos    = IDX_W'(req_payload.position);
   assign ctl.count  = count_ff;
   assign ctl.update = req_fire && do_update;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = entry_bus[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = entry_bus[g+1];
      end
      balist_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(g)),
         .ctl         (ctl),
         .item        (DATA_WIDTH'(req_payload.item_value)),
         .key         (DATA_WIDTH'(req_payload.search_key)),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_bus[g]),
         .match       (match_bus[g])
      );
   end

   always_comb begin
      hit     = |match_ff;
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_pos = IDX_W'(i);
      end
   end

   always_comb begin
      capacity_in   = csr_valid ? csr_data : capacity_ff;
      mid_valid_in  = req_fire ? 1'b1 : (mid_move ? 1'b0 : mid_valid_ff);
      mid_search_in = req_fire ? (req_payload.req_type == OP_SEARCH) : mid_search_ff;
      mid_status_in = req_fire ? status_now : mid_status_ff;
      mid_count_in  = req_fire ? count_in : mid_count_ff;
      rsp_valid_in  = mid_move ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);
      rsp_in        = rsp_ff;
      if (mid_move) begin
         rsp_in.status         = mid_status_ff;
         rsp_in.found          = mid_search_ff && hit;
         rsp_in.found_position = (mid_search_ff && hit) ? 4'(hit_pos) : 4'd0;
         rsp_in.entry_count    = 5'(mid_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= 5'(DEPTH);
         count_ff     <= '0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mid_search_ff <= mid_search_in;
      mid_status_ff <= mid_status_in;
      mid_count_ff  <= mid_count_in;
      if (req_fire) match_ff <= match_bus;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff |=> (count_ff == $past(count_ff)))
      else $error("count changed while transaction in flight");

   a_mid_drain: assert property (@(posedge clock) disable iff (reset)
      mid_move |=> (rsp_valid_ff && !mid_valid_ff))
      else $error("match stage did not drain into response");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> (rsp_ff.status == ST_OK))
      else $error("found flag with non-ok status");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      mid_move |-> (mid_count_ff == count_ff))
      else $error("response count differs from list count");

endmodule

`default_nettype wire

// ===== dv/bounded_array_list_checker.sv =====
// Checker for the bounded array list engine: tracks the list and the capacity register,
// predicts each response and compares it field by field. Depends on balist_pkg.
`default_nettype none

module bounded_array_list_checker
   import balist_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire rsp_payload_type rsp_payload,
   input  wire logic            csr_valid,
   input  wire logic            csr_ready,
   input  wire logic [4:0]      csr_data,
   output int                   results_due,
   output int                   mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_WIDTH-1:0] list_words [DEPTH];
   int                    held = 0;
   logic [4:0]            capacity_reg = 5'd16;
   rsp_payload_type       due_results [$];
   int                    bad = 0;

   function automatic rsp_payload_type apply_list_request(input req_payload_type r);
      rsp_payload_type res;
      int lim;
      int pos;
      int i;
      bit full;
      res = '0;
      lim = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
      full = (held >= lim);
      pos = int'(r.position);
      case (r.req_type)
         OP_APPEND: begin
            if (full) res.status = ST_FULL;
            else begin
               list_words[held] = r.item_value;
               held++;
            end
         end
         OP_INSERT: begin
            if (full) res.status = ST_FULL;
            else if (pos > held) res.status = ST_RANGE;
            else begin
               for (i = held; i > pos; i--) list_words[i] = list_words[i - 1];
               list_words[pos] = r.item_value;
               held++;
            end
         end
         OP_DELETE: begin
            if (pos >= held) res.status = ST_RANGE;
            else begin
               for (i = pos; i + 1 < held; i++) list_words[i] = list_words[i + 1];
               held--;
            end
         end
         default: begin
            // scan downward so the lowest matching position wins
            for (i = held - 1; i >= 0; i--) begin
               if (list_words[i] == r.search_key) begin
                  res.found = 1'b1;
                  res.found_position = 4'(i);
               end
            end
         end
      endcase
      res.entry_count = 5'(held);
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [4:0] want,
                                       input logic [4:0] got);
      if (want !== got) begin
         bad++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         due_results.delete();
         held = 0;
         capacity_reg = 5'd16;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               bad++;
               $display("%0t: response with none outstanding, expected none, actual %p",
                        $time, rsp_payload);
            end else begin
               want = due_results.pop_front();
               check_field("status", want.status, rsp_payload.status);
               check_field("found", want.found, rsp_payload.found);
               check_field("found_position", want.found_position,
                           rsp_payload.found_position);
               check_field("entry_count", want.entry_count, rsp_payload.entry_count);
            end
         end
         if (csr_valid && csr_ready) capacity_reg = csr_data;
         if (req_valid && req_ready) due_results.push_back(apply_list_request(req_payload));
      end
      results_due <= due_results.size();
      mismatches <= bad;
   end

endmodule

`default_nettype wire

// ===== dv/bounded_array_list_engine_unit_tb.sv =====
// Top of the bounded array list engine testbench: clock, reset, directed and random
// transactions, capacity writes and the verdict. Depends on balist_pkg,
// bounded_array_list_engine_unit and bounded_array_list_checker.
`default_nettype none

module bounded_array_list_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import balist_pkg::*;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [4:0]      csr_data;
   int              results_due;
   int              mismatches;
   int              tx_idle_pct = 0;
   int              rx_idle_pct = 0;

   bounded_array_list_engine_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   bounded_array_list_checker list_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .results_due (results_due),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   function automatic req_payload_type make_req(input op_code_type op, input int pos,
                                                 input logic [31:0] word,
                                                 input logic [31:0] key);
      req_payload_type r;
      r.req_type = op;
      r.position = 4'(pos);
      r.item_value = word;
      r.search_key = key;
      return r;
   endfunction

   // half the words come from a small pool so searches hit and duplicates occur
   function automatic logic [31:0] pick_word();
      logic [31:0] pool [6];
      pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h5A5A_A5A5};
      if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 5)];
      return $urandom;
   endfunction

   function automatic req_payload_type random_req(input bit grow, input int lim);
      op_code_type op;
      int roll;
      int pos;
      roll = $urandom_range(0, 99);
      if (grow)
         op = (roll < 40) ? OP_APPEND : (roll < 75) ? OP_INSERT :
              (roll < 85) ? OP_DELETE : OP_SEARCH;
      else
         op = (roll < 10) ? OP_APPEND : (roll < 20) ? OP_INSERT :
              (roll < 70) ? OP_DELETE : OP_SEARCH;
      roll = $urandom_range(0, 9);
      if (roll < 4) pos = $urandom_range(0, 3);
      else if (roll < 8) pos = $urandom_range(0, lim);
      else pos = $urandom_range(0, 15);
      return make_req(op, pos, pick_word(), pick_word());
   endfunction

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct <= rx_pct;
   endtask

   task automatic send_req(input req_payload_type p);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // capacity changes only with no transaction in flight
   task automatic write_capacity(input int value);
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      csr_valid <= 1'b1;
      csr_data <= 5'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int cap_seq [6];
      int ph;
      int k;
      int lim;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_idling(26, 61);

      // empty list, then boundary words, inserts at the ends and in the middle
      send_req(make_req(OP_SEARCH, 0, 32'h0, 32'h0));
      send_req(make_req(OP_DELETE, 0, 32'h0, 32'h0));
      send_req(make_req(OP_DELETE, 15, 32'h0, 32'h0));
      send_req(make_req(OP_INSERT, 1, 32'h1, 32'h0));
      send_req(make_req(OP_INSERT, 0, 32'h8000_0000, 32'h0));
      send_req(make_req(OP_APPEND, 0, 32'h7FFF_FFFF, 32'h0));
      send_req(make_req(OP_APPEND, 0, 32'hFFFF_FFFF, 32'h0));
      send_req(make_req(OP_INSERT, 3, 32'h0, 32'h0));
      send_req(make_req(OP_INSERT, 2, 32'hFFFF_FFFF, 32'h0));
      send_req(make_req(OP_SEARCH, 0, 32'h0, 32'hFFFF_FFFF));
      send_req(make_req(OP_SEARCH, 0, 32'h0, 32'h8000_0000));
      send_req(make_req(OP_SEARCH, 0, 32'h0, 32'h0));
      send_req(make_req(OP_SEARCH, 0, 32'h0, 32'h0000_3039));
      send_req(make_req(OP_INSERT, 15, 32'h5, 32'h0));
      send_req(make_req(OP_DELETE, 5, 32'h0, 32'h0));
      send_req(make_req(OP_DELETE, 0, 32'h0, 32'h0));
      send_req(make_req(OP_DELETE, 3, 32'h0, 32'h0));
      send_req(make_req(OP_SEARCH, 0, 32'h0, 32'hFFFF_FFFF));

      // zero capacity: always full, full wins over a bad position
      write_capacity(0);
      send_req(make_req(OP_APPEND, 0, 32'h1, 32'h0));
      send_req(make_req(OP_INSERT, 15, 32'h1, 32'h0));
      send_req(make_req(OP_DELETE, 1, 32'h0, 32'h0));
      send_req(make_req(OP_SEARCH, 0, 32'h0, 32'h7FFF_FFFF));

      // capacity below the count keeps the entries
      write_capacity(1);
      send_req(make_req(OP_INSERT, 0, 32'h2, 32'h0));
      send_req(make_req(OP_DELETE, 0, 32'h0, 32'h0));
      send_req(make_req(OP_APPEND, 0, 32'h3, 32'h0));

      cap_seq = '{31, 1, 16, $urandom_range(2, 15), 17, $urandom_range(0, 31)};
      for (ph = 0; ph < 6; ph++) begin
         if (ph == 2) set_idling(61, 26);
         if (ph == 4) set_idling(0, 0);
         write_capacity(cap_seq[ph]);
         lim = (cap_seq[ph] > 15) ? 15 : cap_seq[ph];
         for (k = 0; k < 125; k++) begin
            send_req(random_req(((k / 20) % 2) == 0, lim));
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (4) @(posedge clock);
      if (mismatches == 0 && results_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
